FILE: rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: rtl/ifa_pkg.sv
// types, constants and helpers for the integer ascii formatter
package ifa_pkg;

    localparam int TEXT_MAX = 16;
    localparam int TIDX_W   = 4;

    localparam logic [1:0] ACT_SIGNED   = 2'd0;
    localparam logic [1:0] ACT_UNSIGNED = 2'd1;
    localparam logic [1:0] ACT_HEX      = 2'd2;
    localparam logic [1:0] ACT_POINTER  = 2'd3;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_LOW_A = 8'h61;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [31:0] RECIP_10    = 32'hcccc_cccd;
    localparam int          RECIP_SHIFT = 35;

    typedef struct packed {
        logic [31:0] mag;
        logic        hex;
    } t_div_req;

    typedef struct packed {
        logic [31:0] quot;
        logic [3:0]  rem;
    } t_div_rsp;

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] d_ext;
        d_ext = {4'b0000, d};
        if (d < 4'd10) begin
            return CH_ZERO + d_ext;
        end else begin
            return CH_LOW_A + d_ext - 8'd10;
        end
    endfunction

endpackage

FILE: rtl/integer_ascii_formatter.sv
// top level: formats a 32-bit value as decimal or hex ascii, one character a cycle while emitting
//
//  channel   direction  handshake              word
//  -------   ---------  ---------------------  ------------------------------------
//  command   in         start high, busy low   i_value, i_action, i_min_width, i_fill_zero
//  result    out        o_strobe, one cycle    o_character, o_last
//
// an item runs the shared divider through ST_MUL and ST_DIG once per magnitude digit (1 to 10
// digits), sizes the field in ST_CALC, then emits max(width, text) characters in ST_EMIT, one
// per cycle, with width capped at MAX_WIDTH; the pace is set by the divider loop and the single
// character output register.
// reset (synchronous, active low) returns the sequencer to idle and drops the strobe.
// busy stays high from the accepting edge until the last character is registered;
// the receiver takes every strobed word and cannot stall the block.
module integer_ascii_formatter #(
    parameter int MAX_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] i_value,
    input  logic [1:0]  i_action,
    input  logic [6:0]  i_min_width,
    input  logic        i_fill_zero,
    output logic [7:0]  o_character,
    output logic        o_last,
    output logic        o_strobe
);
    import ifa_pkg::*;

    // field width counter and the compare width against the 7-bit port
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int CW  = (WCW > 7) ? WCW : 7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIG,
        ST_CALC,
        ST_EMIT
    } t_state;

    t_state r_state, n_state;

    logic [31:0]       r_mag, n_mag;
    logic              r_hex, n_hex;
    logic              r_neg, n_neg;
    logic              r_ptr, n_ptr;
    logic              r_zpad, n_zpad;
    logic [WCW-1:0]    r_width, n_width;
    logic [WCW-1:0]    r_pad, n_pad;
    logic [1:0]        r_pre, n_pre;
    logic [TIDX_W-1:0] r_ndig, n_ndig;
    logic [TIDX_W-1:0] r_idx, n_idx;
    logic [7:0]        r_char, n_char;
    logic              r_last, n_last;
    logic              r_strobe, n_strobe;

    // digit buffer, least significant digit at index 0
    logic [3:0] r_digits [TEXT_MAX];

    t_div_req w_req;
    t_div_rsp w_rsp;

    logic [CW-1:0]  w_wext;
    logic [1:0]     w_prelen;
    logic [WCW-1:0] w_len;

    assign w_req.mag = r_mag;
    assign w_req.hex = r_hex;

    ifa_divider u_div (
        .i_clk (i_clk),
        .i_req (w_req),
        .o_rsp (w_rsp)
    );

    assign w_wext   = CW'(i_min_width);
    // pointer carries "0x", negative signed carries '-'
    assign w_prelen = r_ptr ? 2'd2 : (r_neg ? 2'd1 : 2'd0);
    assign w_len    = WCW'(r_ndig) + WCW'(w_prelen);

    always_comb begin
        n_state  = r_state;
        n_mag    = r_mag;
        n_hex    = r_hex;
        n_neg    = r_neg;
        n_ptr    = r_ptr;
        n_zpad   = r_zpad;
        n_width  = r_width;
        n_pad    = r_pad;
        n_pre    = r_pre;
        n_ndig   = r_ndig;
        n_idx    = r_idx;
        n_char   = r_char;
        n_last   = 1'b0;
        n_strobe = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    // two's complement magnitude for negative signed input
                    n_neg   = (i_action == ACT_SIGNED) && i_value[31];
                    n_mag   = n_neg ? (32'd0 - i_value) : i_value;
                    n_hex   = (i_action == ACT_HEX) || (i_action == ACT_POINTER);
                    n_ptr   = (i_action == ACT_POINTER);
                    n_zpad  = i_fill_zero;
                    // minimum width saturates at the field limit
                    n_width = (w_wext > CW'(MAX_WIDTH)) ? WCW'(MAX_WIDTH)
                                                        : w_wext[WCW-1:0];
                    n_ndig  = '0;
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                // divider samples r_mag at this edge
                n_state = ST_DIG;
            end
            ST_DIG: begin
                n_mag   = w_rsp.quot;
                n_ndig  = r_ndig + 1'b1;
                // zero still yields its single '0' digit
                n_state = (w_rsp.quot == 32'd0) ? ST_CALC : ST_MUL;
            end
            ST_CALC: begin
                n_pad   = (r_width > w_len) ? (r_width - w_len) : '0;
                n_pre   = w_prelen;
                n_idx   = r_ndig - 1'b1;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                if (r_pad != '0) begin
                    // padding goes ahead of sign and prefix
                    n_char = r_zpad ? CH_ZERO : CH_SPACE;
                    n_pad  = r_pad - 1'b1;
                end else if (r_pre != 2'd0) begin
                    if (r_ptr) begin
                        n_char = (r_pre == 2'd2) ? CH_ZERO : CH_X;
                    end else begin
                        n_char = CH_MINUS;
                    end
                    n_pre = r_pre - 1'b1;
                end else begin
                    n_char = digit_char(r_digits[r_idx]);
                    if (r_idx == '0) begin
                        n_last  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_last   <= n_last;
        end
        r_mag   <= n_mag;
        r_hex   <= n_hex;
        r_neg   <= n_neg;
        r_ptr   <= n_ptr;
        r_zpad  <= n_zpad;
        r_width <= n_width;
        r_pad   <= n_pad;
        r_pre   <= n_pre;
        r_ndig  <= n_ndig;
        r_idx   <= n_idx;
        r_char  <= n_char;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIG) begin
            r_digits[r_ndig] <= w_rsp.rem;
        end
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_character = r_char;
    assign o_last      = r_last;
    assign o_strobe    = r_strobe;

`include "assert_macros.svh"

    // an accepted command holds the block busy on the next cycle
    `ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    // last only ever marks a strobed word
    `ASSERT_SAME(a_last_strobed, i_clk, i_rst_n, o_last, o_strobe)
    // more characters pending means the sequencer is still working
    `ASSERT_SAME(a_mid_busy, i_clk, i_rst_n, o_strobe && !o_last, busy)
    // the final character frees the block in the same cycle
    `ASSERT_SAME(a_last_free, i_clk, i_rst_n, o_strobe && o_last, !busy)

endmodule

FILE: rtl/ifa_divider.sv
// shared divide-by-radix unit: one quotient digit per request, answered in the cycle after the request
module ifa_divider (
    input  logic              i_clk,
    input  ifa_pkg::t_div_req i_req,
    output ifa_pkg::t_div_rsp o_rsp
);
    import ifa_pkg::*;

    logic [63:0] w_prod;
    logic [28:0] r_prod_hi;
    logic [31:0] r_mag;
    logic        r_hex;
    logic [31:0] w_quot;
    logic [3:0]  w_q10_lo;

    // reciprocal multiply, registered before the correction
    assign w_prod = {32'd0, i_req.mag} * {32'd0, RECIP_10};

    always_ff @(posedge i_clk) begin
        r_prod_hi <= w_prod[63:RECIP_SHIFT];
        r_mag     <= i_req.mag;
        r_hex     <= i_req.hex;
    end

    assign w_quot   = r_hex ? {4'b0000, r_mag[31:4]} : {3'b000, r_prod_hi};
    // remainder is below 10, so the low nibble of mag - 10*q is exact
    assign w_q10_lo = w_quot[3:0] * 4'd10;

    assign o_rsp.quot = w_quot;
    assign o_rsp.rem  = r_hex ? r_mag[3:0] : (r_mag[3:0] - w_q10_lo);

endmodule

FILE: tb/tb_integer_ascii_formatter.sv
`timescale 1ns / 100ps
// testbench for integer_ascii_formatter: directed and random commands checked against a text predictor

module tb_integer_ascii_formatter;
    import ifa_pkg::*;

    // scoreboard: formats each accepted command into the characters it must produce
    class text_checker;
        typedef struct packed {
            logic [7:0] ch;
            logic       last;
        } t_text_char;

        localparam int MAX_FIELD = 64;

        t_text_char pending_chars[$];
        int         n_err;

        function new();
            n_err = 0;
        endfunction

        function void report(string what, logic [7:0] exp_ch, logic exp_last,
                             logic [7:0] got_ch, logic got_last);
            n_err++;
            if (n_err <= 10) begin
                $display("%s: expected char %h last %b, got char %h last %b",
                         what, exp_ch, exp_last, got_ch, got_last);
            end
        endfunction

        // queue the full expected text of one accepted command
        function void note_command(logic [31:0] value, logic [1:0] action,
                                   logic [6:0] min_width, logic fill_zero);
            logic [7:0]  digits[$];
            logic [7:0]  text[$];
            logic [31:0] mag;
            logic [31:0] radix;
            logic [3:0]  d;
            logic        neg;
            int          width;
            int          total;
            int          pad;
            t_text_char  c;
            neg   = (action == ACT_SIGNED) && value[31];
            mag   = neg ? (32'd0 - value) : value;
            radix = (action == ACT_HEX || action == ACT_POINTER) ? 32'd16 : 32'd10;
            // magnitude digits, least significant first, pushed to the front
            do begin
                d = 4'(mag % radix);
                digits.push_front((d < 4'd10) ? (CH_ZERO + {4'b0000, d})
                                              : (CH_LOW_A + {4'b0000, d} - 8'd10));
                mag = mag / radix;
            end while (mag != 32'd0);
            if (action == ACT_POINTER) begin
                text.push_back(CH_ZERO);
                text.push_back(CH_X);
            end else if (neg) begin
                text.push_back(CH_MINUS);
            end
            foreach (digits[i]) text.push_back(digits[i]);
            width = (int'(min_width) > MAX_FIELD) ? MAX_FIELD : int'(min_width);
            total = (width > text.size()) ? width : text.size();
            if (total > MAX_FIELD) total = MAX_FIELD;
            pad = total - text.size();
            if (pad < 0) pad = 0;
            for (int k = 0; k < total; k++) begin
                if (k < pad) c.ch = fill_zero ? CH_ZERO : CH_SPACE;
                else         c.ch = text[k - pad];
                c.last = (k == total - 1);
                pending_chars.push_back(c);
            end
        endfunction

        // compare one strobed character with the oldest expected one
        function void check_char(logic [7:0] ch, logic last);
            t_text_char c;
            if (pending_chars.size() == 0) begin
                report("unexpected character", 8'h00, 1'b0, ch, last);
            end else begin
                c = pending_chars.pop_front();
                if (ch !== c.ch || last !== c.last) begin
                    report("character mismatch", c.ch, c.last, ch, last);
                end
            end
        endfunction
    endclass

    // watchdog limit, chosen above the length of the slowest correct run
    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_RANDOM     = 250;
    // divider loop plus sizing plus a full 64-character field, with margin
    localparam int DRAIN_CYCLES = 120;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [31:0] i_value;
    logic [1:0]  i_action;
    logic [6:0]  i_min_width;
    logic        i_fill_zero;
    logic [7:0]  o_character;
    logic        o_last;
    logic        o_strobe;

    text_checker sb;
    int          cycles = 0;

    integer_ascii_formatter u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_action    (i_action),
        .i_min_width (i_min_width),
        .i_fill_zero (i_fill_zero),
        .o_character (o_character),
        .o_last      (o_last),
        .o_strobe    (o_strobe)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog: a hung block ends the run as a failure
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_integer_ascii_formatter: done, errors");
            $finish;
        end
    end

    // result monitor: every strobed word is taken at the rising edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe === 1'b1 && sb != null) begin
            sb.check_char(o_character, o_last);
        end
    end

    // present one command at the falling edge and hold it until busy is low at a rising edge
    task automatic send_command(input logic [31:0] value, input logic [1:0] action,
                                input logic [6:0] min_width, input logic fill_zero);
        @(negedge i_clk);
        start       <= 1'b1;
        i_value     <= value;
        i_action    <= action;
        i_min_width <= min_width;
        i_fill_zero <= fill_zero;
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(value, action, min_width, fill_zero);
    endtask

    // sender gap: start low for a gap whose length is given by n, none when n is zero
    task automatic idle_cycles(input int n);
        if (n > 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge i_clk);
        end
    endtask

    // random command, biased toward the interesting values and mostly short fields
    task automatic random_command();
        logic [31:0] value;
        logic [6:0]  width;
        case ($urandom_range(0, 5))
            0:       value = $urandom_range(0, 99);
            1:       value = 32'd0 - 32'($urandom_range(1, 1000));
            2:       value = (32'd1 << $urandom_range(0, 31)) - 32'($urandom_range(0, 1));
            3: begin
                case ($urandom_range(0, 3))
                    0:       value = 32'h0000_0000;
                    1:       value = 32'hffff_ffff;
                    2:       value = 32'h8000_0000;
                    default: value = 32'h7fff_ffff;
                endcase
            end
            default: value = $urandom;
        endcase
        case ($urandom_range(0, 9))
            7:       width = 7'($urandom_range(17, 64));
            8:       width = 7'($urandom_range(65, 127));
            9:       width = 7'd0;
            default: width = 7'($urandom_range(0, 16));
        endcase
        send_command(value, 2'($urandom_range(0, 3)), width, 1'($urandom_range(0, 1)));
    endtask

    task automatic wait_all_chars();
        while (sb.pending_chars.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        int gap_mode;
        sb          = new();
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = 32'd0;
        i_action    = ACT_SIGNED;
        i_min_width = 7'd0;
        i_fill_zero = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: zero and all-ones in every action
        send_command(32'h0000_0000, ACT_SIGNED,   7'd0,   1'b0);
        send_command(32'h0000_0000, ACT_UNSIGNED, 7'd0,   1'b1);
        send_command(32'h0000_0000, ACT_HEX,      7'd0,   1'b0);
        send_command(32'h0000_0000, ACT_POINTER,  7'd0,   1'b0);
        idle_cycles(3);
        send_command(32'hffff_ffff, ACT_SIGNED,   7'd0,   1'b0);
        send_command(32'hffff_ffff, ACT_UNSIGNED, 7'd0,   1'b0);
        send_command(32'hffff_ffff, ACT_HEX,      7'd0,   1'b1);
        send_command(32'hffff_ffff, ACT_POINTER,  7'd0,   1'b0);
        // most negative and most positive signed
        send_command(32'h8000_0000, ACT_SIGNED,   7'd0,   1'b0);
        send_command(32'h7fff_ffff, ACT_SIGNED,   7'd0,   1'b0);
        send_command(32'h8000_0000, ACT_UNSIGNED, 7'd0,   1'b0);
        // padding goes in front of sign and prefix
        send_command(32'hffff_ffd6, ACT_SIGNED,   7'd8,   1'b1);
        send_command(32'hffff_ffd6, ACT_SIGNED,   7'd8,   1'b0);
        send_command(32'h0000_00ab, ACT_POINTER,  7'd10,  1'b1);
        idle_cycles(7);
        // width equal to and below the text length
        send_command(32'hdead_beef, ACT_HEX,      7'd8,   1'b1);
        send_command(32'd12345,     ACT_UNSIGNED, 7'd3,   1'b1);
        send_command(32'h0123_abcd, ACT_HEX,      7'd1,   1'b0);
        send_command(32'd1,         ACT_SIGNED,   7'd1,   1'b1);
        send_command(32'd10,        ACT_UNSIGNED, 7'd2,   1'b1);
        // full field and widths that saturate
        send_command(32'd7,         ACT_SIGNED,   7'd64,  1'b1);
        send_command(32'd9,         ACT_UNSIGNED, 7'd65,  1'b0);
        send_command(32'h0000_0010, ACT_HEX,      7'd127, 1'b1);
        send_command(32'h1234_5678, ACT_POINTER,  7'd100, 1'b0);

        // random: gaps drawn per word, with some blocks run back to back
        gap_mode = 1;
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 25 == 0) gap_mode = $urandom_range(0, 2);
            // hold the sender off once until the block has drained completely
            if (i == N_RANDOM / 2) begin
                idle_cycles(1);
                wait_all_chars();
            end
            random_command();
            idle_cycles((gap_mode == 0) ? 0 : $urandom_range(0, 14));
        end

        idle_cycles(1);
        wait_all_chars();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_chars.size() != 0) begin
            sb.report("missing characters", sb.pending_chars[0].ch, sb.pending_chars[0].last,
                      8'h00, 1'b0);
        end
        if (sb.n_err == 0) begin
            $display("tb_integer_ascii_formatter: done, clean");
        end else begin
            $display("tb_integer_ascii_formatter: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/ifa_pkg.sv
rtl/ifa_divider.sv
rtl/integer_ascii_formatter.sv
tb/tb_integer_ascii_formatter.sv
